FILE: rtl/core/fc_pkg.sv
// fc_pkg: shared types, register codes and constants of the fingertip counter.
// Used by every module under rtl/core; depends on nothing.
package fc_pkg;

    localparam int COUNT_BITS = 3;
    localparam int S_BITS     = 11;
    localparam int FRAC_BITS  = 8;
    localparam int GAP_BITS   = 8;

    localparam logic [GAP_BITS-1:0]   GAP_RESET  = 8'd18;
    localparam logic [COUNT_BITS-1:0] MAXF_RESET = 3'd5;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 3'd7;

    // outer ring: d2 * 100 <= 1444 * r2, i.e. d <= 3.8 r
    localparam logic [6:0]  OUTER_DEN = 7'd100;
    localparam logic [10:0] OUTER_NUM = 11'd1444;

    // smoothing in Q3.8: 0.34 as 87/256, round up above 0.8 (205/256)
    localparam logic [6:0]           SMOOTH_NUM = 7'd87;
    localparam logic [FRAC_BITS-1:0] FRAC_LIMIT = 8'd205;
    localparam logic [S_BITS-1:0]    S_MAX      = 11'd2047;

    typedef enum logic {
        REG_GAP_LIMIT   = 1'b0,
        REG_MAX_FINGERS = 1'b1
    } fc_reg_t;

    typedef struct packed {
        logic [GAP_BITS-1:0]   gap_limit;
        logic [COUNT_BITS-1:0] max_fingers;
    } fc_cfg_t;

    typedef struct packed {
        logic frame_start;
        logic last;
        logic prev_y_ok;
        logic first_y_ok;
    } fc_flags_t;

    function automatic logic [COUNT_BITS-1:0] fc_sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + 3'd1;
    endfunction

endpackage

FILE: rtl/core/fc_config.sv
// fc_config: APB-style register file holding gap_limit and max_fingers.
// Depends on fc_pkg.
module fc_config import fc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output fc_cfg_t     cfg
);

    logic    wr_en;
    fc_reg_t reg_idx;
    fc_cfg_t cfg_reg;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = fc_reg_t'(paddr[2]);
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gap_limit   <= GAP_RESET;
            cfg_reg.max_fingers <= MAXF_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GAP_LIMIT:   cfg_reg.gap_limit   <= pwdata[GAP_BITS-1:0];
                REG_MAX_FINGERS: cfg_reg.max_fingers <= pwdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAP_LIMIT:   prdata = {{(32-GAP_BITS){1'b0}}, cfg_reg.gap_limit};
            REG_MAX_FINGERS: prdata = {{(32-COUNT_BITS){1'b0}}, cfg_reg.max_fingers};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/fc_geometry.sv
// fc_geometry: input register and squared-distance stage of the fingertip counter.
// Tracks previous and first hull point; registers products for fc_tally. Depends on fc_pkg.
module fc_geometry import fc_pkg::*; #(
    parameter int CW = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CW-1:0]       s_point_x,
    input  logic [CW-1:0]       s_point_y,
    input  logic [CW-1:0]       s_center_x,
    input  logic [CW-1:0]       s_center_y,
    input  logic [CW-2:0]       s_palm_radius,
    input  logic                s_last_point,
    input  logic [GAP_BITS-1:0] gap_limit,
    input  logic                b_move,
    output logic                b_valid,
    output fc_flags_t           b_flags,
    output logic [2*CW-1:0]     gx2,
    output logic [2*CW-1:0]     gy2,
    output logic [2*CW-1:0]     px2,
    output logic [2*CW-1:0]     py2,
    output logic [2*CW-1:0]     fx2,
    output logic [2*CW-1:0]     fy2,
    output logic [2*CW-3:0]     r2,
    output logic [2*GAP_BITS-1:0] gap2
);

    // stage A: accepted request
    logic          a_valid_reg;
    logic [CW-1:0] a_x_reg, a_y_reg, a_cx_reg, a_cy_reg;
    logic [CW-2:0] a_r_reg;
    logic          a_last_reg;

    // frame tracking
    logic          in_frame_reg;
    logic [CW-1:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;

    // stage B: products
    logic            b_valid_reg;
    fc_flags_t       flags_reg, flags_next;
    logic [2*CW-1:0] gx2_reg, gy2_reg, px2_reg, py2_reg, fx2_reg, fy2_reg;
    logic [2*CW-1:0] gx2_next, gy2_next, px2_next, py2_next, fx2_next, fy2_next;
    logic [2*CW-3:0] r2_reg, r2_next;
    logic [2*GAP_BITS-1:0] gap2_reg, gap2_next;

    logic          a_move;
    logic [CW-1:0] src_fx, src_fy;
    logic [CW:0]   y_limit;

    function automatic logic [2*CW-1:0] sq_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW-1:0] d;
        d = (a > b) ? a - b : b - a;
        return (2*CW)'(d) * (2*CW)'(d);
    endfunction

    assign a_move  = a_valid_reg && (!b_valid_reg || b_move);
    assign s_ready = !a_valid_reg || a_move;

    always_comb begin
        flags_next.frame_start = !in_frame_reg;
        flags_next.last        = a_last_reg;
        // first point of a frame that opens here is the current point
        src_fx    = in_frame_reg ? first_x_reg : a_x_reg;
        src_fy    = in_frame_reg ? first_y_reg : a_y_reg;
        y_limit   = {1'b0, a_cy_reg} + {2'b00, a_r_reg};
        flags_next.prev_y_ok  = {1'b0, prev_y_reg} <= y_limit;
        flags_next.first_y_ok = {1'b0, src_fy} <= y_limit;
        gx2_next  = sq_diff(prev_x_reg, a_x_reg);
        gy2_next  = sq_diff(prev_y_reg, a_y_reg);
        px2_next  = sq_diff(prev_x_reg, a_cx_reg);
        py2_next  = sq_diff(prev_y_reg, a_cy_reg);
        fx2_next  = sq_diff(src_fx, a_cx_reg);
        fy2_next  = sq_diff(src_fy, a_cy_reg);
        r2_next   = (2*CW-2)'(a_r_reg) * (2*CW-2)'(a_r_reg);
        gap2_next = (2*GAP_BITS)'(gap_limit) * (2*GAP_BITS)'(gap_limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            in_frame_reg <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            first_x_reg  <= '0;
            first_y_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                a_valid_reg <= 1'b1;
            end else if (a_move) begin
                a_valid_reg <= 1'b0;
            end
            if (a_move) begin
                b_valid_reg  <= 1'b1;
                prev_x_reg   <= a_x_reg;
                prev_y_reg   <= a_y_reg;
                in_frame_reg <= !a_last_reg;
                if (!in_frame_reg) begin
                    first_x_reg <= a_x_reg;
                    first_y_reg <= a_y_reg;
                end
            end else if (b_move) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_x_reg    <= s_point_x;
            a_y_reg    <= s_point_y;
            a_cx_reg   <= s_center_x;
            a_cy_reg   <= s_center_y;
            a_r_reg    <= s_palm_radius;
            a_last_reg <= s_last_point;
        end
        if (a_move) begin
            flags_reg <= flags_next;
            gx2_reg   <= gx2_next;
            gy2_reg   <= gy2_next;
            px2_reg   <= px2_next;
            py2_reg   <= py2_next;
            fx2_reg   <= fx2_next;
            fy2_reg   <= fy2_next;
            r2_reg    <= r2_next;
            gap2_reg  <= gap2_next;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_flags = flags_reg;
    assign gx2     = gx2_reg;
    assign gy2     = gy2_reg;
    assign px2     = px2_reg;
    assign py2     = py2_reg;
    assign fx2     = fx2_reg;
    assign fy2     = fy2_reg;
    assign r2      = r2_reg;
    assign gap2    = gap2_reg;

endmodule

FILE: rtl/core/fc_qualify.sv
// fc_qualify: ring test of one candidate against the palm, 2r <= d <= 3.8r, row not below the limit.
// Depends on fc_pkg.
module fc_qualify import fc_pkg::*; #(
    parameter int CW = 12
) (
    input  logic [2*CW-1:0] dx2,
    input  logic [2*CW-1:0] dy2,
    input  logic [2*CW-3:0] r2,
    input  logic            y_ok,
    output logic            ok
);

    localparam int QW = 2*CW + 9;

    logic [2*CW:0] d2;
    logic [QW-1:0] d2_scaled, r2_scaled;

    always_comb begin
        d2        = {1'b0, dx2} + {1'b0, dy2};
        d2_scaled = QW'(d2) * QW'(OUTER_DEN);
        r2_scaled = QW'(r2) * QW'(OUTER_NUM);
        ok        = y_ok && (d2 >= {1'b0, r2, 2'b00}) && (d2_scaled <= r2_scaled);
    end

endmodule

FILE: rtl/core/fc_tally.sv
// fc_tally: gap detection and per-frame candidate count, capped at max_fingers.
// Depends on fc_pkg and fc_qualify.
module fc_tally import fc_pkg::*; #(
    parameter int CW = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  b_valid,
    input  fc_flags_t             b_flags,
    input  logic [2*CW-1:0]       gx2,
    input  logic [2*CW-1:0]       gy2,
    input  logic [2*CW-1:0]       px2,
    input  logic [2*CW-1:0]       py2,
    input  logic [2*CW-1:0]       fx2,
    input  logic [2*CW-1:0]       fy2,
    input  logic [2*CW-3:0]       r2,
    input  logic [2*GAP_BITS-1:0] gap2,
    input  logic [COUNT_BITS-1:0] max_fingers,
    input  logic                  c_free,
    output logic                  b_move,
    output logic                  c_push,
    output logic [COUNT_BITS-1:0] c_count
);

    logic                  gap_seen_reg, gap_seen_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  prev_ok, first_ok, gap_hit;
    logic [2*CW:0]         gap_d2;

    fc_qualify #(.CW(CW)) u_prev_q (
        .dx2 (px2),
        .dy2 (py2),
        .r2  (r2),
        .y_ok(b_flags.prev_y_ok),
        .ok  (prev_ok)
    );

    fc_qualify #(.CW(CW)) u_first_q (
        .dx2 (fx2),
        .dy2 (fy2),
        .r2  (r2),
        .y_ok(b_flags.first_y_ok),
        .ok  (first_ok)
    );

    // frame-end requests wait for the smoothing stage; others retire here
    assign b_move = b_valid && (!b_flags.last || c_free);
    assign c_push = b_move && b_flags.last;

    always_comb begin
        gap_d2        = {1'b0, gx2} + {1'b0, gy2};
        gap_hit       = !b_flags.frame_start && (gap_d2 > (2*CW+1)'(gap2));
        gap_seen_next = b_flags.frame_start ? 1'b0 : gap_seen_reg;
        total_next    = b_flags.frame_start ? '0 : total_reg;
        if (gap_hit) begin
            gap_seen_next = 1'b1;
            if (prev_ok) begin
                total_next = fc_sat_inc(total_next);
            end
        end
        // no gap in the whole frame: the first point is the only candidate
        if (b_flags.last && !gap_seen_next && first_ok) begin
            total_next = fc_sat_inc(total_next);
        end
        c_count = (total_next < max_fingers) ? total_next : max_fingers;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_seen_reg <= 1'b0;
            total_reg    <= '0;
        end else if (b_move) begin
            gap_seen_reg <= b_flags.last ? 1'b0 : gap_seen_next;
            total_reg    <= b_flags.last ? '0 : total_next;
        end
    end

endmodule

FILE: rtl/core/fc_smooth.sv
// fc_smooth: frame-to-frame smoothing in Q3.8, rounding and the result register.
// Depends on fc_pkg.
module fc_smooth import fc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  c_push,
    input  logic [COUNT_BITS-1:0] c_count,
    output logic                  c_free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_tip_count,
    output logic [COUNT_BITS-1:0] m_raw_count
);

    localparam int SUM_BITS  = S_BITS + 2;
    localparam int PROD_BITS = SUM_BITS + 7;

    logic                  c_valid_reg;
    logic [COUNT_BITS-1:0] c_count_reg;
    logic [S_BITS-1:0]     s_reg, s_next;
    logic [COUNT_BITS-1:0] prev_raw_reg;
    logic                  first_frame_reg;
    logic                  m_valid_reg;
    logic [COUNT_BITS-1:0] finger_reg, finger_next, raw_reg;

    logic                  o_load;
    logic [SUM_BITS-1:0]   sum;
    logic [PROD_BITS-1:0]  prod;
    logic [PROD_BITS-FRAC_BITS-1:0] scaled;
    logic [COUNT_BITS:0]   rounded;

    assign o_load = c_valid_reg && (!m_valid_reg || m_ready);
    assign c_free = !c_valid_reg || o_load;

    always_comb begin
        sum    = SUM_BITS'(s_reg)
               + (SUM_BITS'({1'b0, prev_raw_reg} + {1'b0, c_count_reg}) << FRAC_BITS);
        prod   = PROD_BITS'(sum) * PROD_BITS'(SMOOTH_NUM);
        scaled = prod[PROD_BITS-1:FRAC_BITS];
        if (first_frame_reg) begin
            s_next = {c_count_reg, {FRAC_BITS{1'b0}}};
        end else if (scaled > (PROD_BITS-FRAC_BITS)'(S_MAX)) begin
            s_next = S_MAX;
        end else begin
            s_next = scaled[S_BITS-1:0];
        end
        rounded = {1'b0, s_next[S_BITS-1:FRAC_BITS]}
                + {{COUNT_BITS{1'b0}}, (s_next[FRAC_BITS-1:0] >= FRAC_LIMIT)};
        finger_next = rounded[COUNT_BITS] ? COUNT_MAX : rounded[COUNT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            s_reg           <= '0;
            prev_raw_reg    <= '0;
            first_frame_reg <= 1'b1;
        end else begin
            if (c_push) begin
                c_valid_reg <= 1'b1;
            end else if (o_load) begin
                c_valid_reg <= 1'b0;
            end
            if (o_load) begin
                m_valid_reg     <= 1'b1;
                s_reg           <= s_next;
                prev_raw_reg    <= c_count_reg;
                first_frame_reg <= 1'b0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_push) begin
            c_count_reg <= c_count;
        end
        if (o_load) begin
            finger_reg <= finger_next;
            raw_reg    <= c_count_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tip_count = finger_reg;
    assign m_raw_count = raw_reg;

endmodule

FILE: rtl/core/fingertip_counter.sv
// fingertip_counter: top level, counts fingertips on a hand hull and smooths the count.
// Depends on fc_pkg, fc_config, fc_geometry, fc_tally, fc_smooth.
//
//   port group   direction  handshake          content
//   s_*          in         s_valid / s_ready  one hull point with palm centre and radius
//   m_*          out        m_valid / m_ready  tip_count and raw_count at frame end
//   p*           in/out     psel & penable     gap_limit at 0x0, max_fingers at 0x4
//
// One hull point is taken per cycle unless a stalled m_ready backs up the pipeline. A point
// with s_last_point set passes the input, product, count and result registers to reach m_*.
// Reset (aresetn low, synchronous) empties the pipeline and restores the registers;
// no clearing pass. A stalled m_ready holds only frame-end requests; points keep
// flowing until a third frame-end request waits behind full count and result registers.
module fingertip_counter import fc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_point_x,
    input  logic [COORD_BITS-1:0] s_point_y,
    input  logic [COORD_BITS-1:0] s_center_x,
    input  logic [COORD_BITS-1:0] s_center_y,
    input  logic [COORD_BITS-2:0] s_palm_radius,
    input  logic                  s_last_point,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_tip_count,
    output logic [COUNT_BITS-1:0] m_raw_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = COORD_BITS;

    fc_cfg_t               cfg;
    logic                  b_valid, b_move, c_push, c_free;
    fc_flags_t             b_flags;
    logic [2*CW-1:0]       gx2, gy2, px2, py2, fx2, fy2;
    logic [2*CW-3:0]       r2;
    logic [2*GAP_BITS-1:0] gap2;
    logic [COUNT_BITS-1:0] c_count;

    fc_config u_config (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    fc_geometry #(.CW(CW)) u_geometry (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_palm_radius(s_palm_radius),
        .s_last_point (s_last_point),
        .gap_limit    (cfg.gap_limit),
        .b_move       (b_move),
        .b_valid      (b_valid),
        .b_flags      (b_flags),
        .gx2          (gx2),
        .gy2          (gy2),
        .px2          (px2),
        .py2          (py2),
        .fx2          (fx2),
        .fy2          (fy2),
        .r2           (r2),
        .gap2         (gap2)
    );

    fc_tally #(.CW(CW)) u_tally (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .b_valid    (b_valid),
        .b_flags    (b_flags),
        .gx2        (gx2),
        .gy2        (gy2),
        .px2        (px2),
        .py2        (py2),
        .fx2        (fx2),
        .fy2        (fy2),
        .r2         (r2),
        .gap2       (gap2),
        .max_fingers(cfg.max_fingers),
        .c_free     (c_free),
        .b_move     (b_move),
        .c_push     (c_push),
        .c_count    (c_count)
    );

    fc_smooth u_smooth (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .c_push     (c_push),
        .c_count    (c_count),
        .c_free     (c_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tip_count(m_tip_count),
        .m_raw_count(m_raw_count)
    );

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for fingertip_counter; streams hull frames, predicts the
// per-frame counts in its own model and compares every result request at the m_ side.
// Depends on fc_pkg (COUNT_BITS, fc_reg_t) and the fingertip_counter RTL.
module testbench;
    import fc_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF     = 400;
    localparam int SMOOTH_GAIN  = 87;
    localparam int ROUND_UP_AT  = 205;
    localparam int SMOOTH_CEIL  = 2047;
    localparam int TIP_CEIL     = 7;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-2:0] palm_radius;
        logic                  last_point;
    } hull_point_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] tip_count;
        logic [COUNT_BITS-1:0] raw_count;
    } frame_count_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_point_x = '0;
    logic [COORD_BITS-1:0] s_point_y = '0;
    logic [COORD_BITS-1:0] s_center_x = '0;
    logic [COORD_BITS-1:0] s_center_y = '0;
    logic [COORD_BITS-2:0] s_palm_radius = '0;
    logic                  s_last_point = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COUNT_BITS-1:0] m_tip_count;
    logic [COUNT_BITS-1:0] m_raw_count;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    fingertip_counter #(.COORD_BITS(COORD_BITS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_palm_radius (s_palm_radius),
        .s_last_point  (s_last_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tip_count   (m_tip_count),
        .m_raw_count   (m_raw_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model copy of the registers and the frame state
    logic [7:0]            gap_cfg = 8'd18;
    logic [2:0]            cap_cfg = 3'd5;
    logic [COORD_BITS-1:0] trace_x = '0, trace_y = '0;
    logic [COORD_BITS-1:0] start_x = '0, start_y = '0;
    bit                    frame_open = 1'b0;
    bit                    gap_found = 1'b0;
    logic [2:0]            tip_total = '0;
    logic [10:0]           smooth_q38 = '0;
    logic [2:0]            last_raw = '0;
    bit                    awaiting_first = 1'b1;

    frame_count_t expected_counts[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    int  points_sent = 0;
    int  frames_sent = 0;
    int  results_seen = 0;
    int  settings_used = 0;
    int  hold_cycles = 0;
    bit  no_idle = 1'b0;

    function automatic int pick_idle();
        int k;
        k = $urandom_range(0, 99);
        if (no_idle || k < 65) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic longint unsigned sq_span(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                                                logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by);
        longint unsigned dx, dy;
        dx = (ax > bx) ? 64'(ax) - 64'(bx) : 64'(bx) - 64'(ax);
        dy = (ay > by) ? 64'(ay) - 64'(by) : 64'(by) - 64'(ay);
        return dx * dx + dy * dy;
    endfunction

    // fingertip ring: 2r <= d <= 3.8r, and not below the palm's lower edge
    function automatic bit in_finger_ring(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                          logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                                          logic [COORD_BITS-2:0] r);
        longint unsigned d2, r2;
        d2 = sq_span(x, y, cx, cy);
        r2 = 64'(r) * 64'(r);
        return (d2 >= 4 * r2) && (d2 * 100 <= 1444 * r2) && (64'(y) <= 64'(cy) + 64'(r));
    endfunction

    task automatic predict_frame_count(input hull_point_t p);
        longint unsigned s, whole;
        logic [2:0]      n;
        frame_count_t    res;
        if (frame_open) begin
            if (sq_span(trace_x, trace_y, p.point_x, p.point_y) > 64'(gap_cfg) * 64'(gap_cfg)) begin
                gap_found = 1'b1;
                if (in_finger_ring(trace_x, trace_y, p.center_x, p.center_y, p.palm_radius))
                    tip_total += (tip_total != TIP_CEIL);
            end
        end else begin
            start_x = p.point_x;
            start_y = p.point_y;
            gap_found = 1'b0;
            tip_total = '0;
        end
        trace_x = p.point_x;
        trace_y = p.point_y;
        frame_open = 1'b1;
        if (!p.last_point) return;

        // no gap in the whole frame: the first point stands as the only candidate
        if (!gap_found && in_finger_ring(start_x, start_y, p.center_x, p.center_y, p.palm_radius))
            tip_total += (tip_total != TIP_CEIL);
        n = (tip_total < cap_cfg) ? tip_total : cap_cfg;
        if (awaiting_first) begin
            s = 64'(n) << 8;
            awaiting_first = 1'b0;
        end else begin
            s = (SMOOTH_GAIN * (64'(smooth_q38) + (64'(last_raw) << 8) + (64'(n) << 8))) >> 8;
            if (s > SMOOTH_CEIL) s = SMOOTH_CEIL;
        end
        smooth_q38 = s[10:0];
        last_raw = n;
        whole = s >> 8;
        if (s[7:0] >= ROUND_UP_AT) whole++;
        if (whole > TIP_CEIL) whole = TIP_CEIL;
        res.tip_count = whole[2:0];
        res.raw_count = n;
        expected_counts.insert(expected_counts.size(), res);
        frame_open = 1'b0;
        gap_found = 1'b0;
        tip_total = '0;
    endtask

    // offer one hull point and hold it until the block takes the request
    task automatic send_point(input hull_point_t p);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_point_x     <= p.point_x;
        s_point_y     <= p.point_y;
        s_center_x    <= p.center_x;
        s_center_y    <= p.center_y;
        s_palm_radius <= p.palm_radius;
        s_last_point  <= p.last_point;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_frame_count(p);
        points_sent++;
        if (p.last_point) frames_sent++;
    endtask

    function automatic hull_point_t pt(int x, int y, int cx, int cy, int r, bit last);
        hull_point_t p;
        p.point_x = COORD_BITS'(x);
        p.point_y = COORD_BITS'(y);
        p.center_x = COORD_BITS'(cx);
        p.center_y = COORD_BITS'(cy);
        p.palm_radius = (COORD_BITS-1)'(r);
        p.last_point = last;
        return p;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'd4095;
        return COORD_BITS'(v);
    endfunction

    // drop valid, drain the expected results, then let the pipeline empty out
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input fc_reg_t which, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (which)
            REG_GAP_LIMIT:   gap_cfg = value[7:0];
            REG_MAX_FINGERS: cap_cfg = value[2:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int gap, input int cap);
        settle();
        write_register(REG_GAP_LIMIT, gap);
        write_register(REG_MAX_FINGERS, cap);
        settings_used++;
    endtask

    // random hull frames: ring points, small steps, noise and gapless frames
    task automatic run_random_frames(input int budget);
        hull_point_t p;
        int sent, len, k, span, mode, step, side;
        logic [COORD_BITS-1:0] cx, cy, px, py;
        logic [COORD_BITS-2:0] r;
        sent = 0;
        px = '0;
        py = '0;
        while (sent < budget) begin
            mode = $urandom_range(0, 99);
            k = $urandom_range(0, 99);
            if (mode < 12) begin
                cx = COORD_BITS'($urandom_range(1200, 2800));
                cy = COORD_BITS'($urandom_range(1200, 2800));
                r = (COORD_BITS-1)'($urandom_range(20, 300));
                len = $urandom_range(8, 14);
            end else begin
                cx = COORD_BITS'((k < 15) ? $urandom_range(0, 4095) : $urandom_range(300, 3800));
                cy = COORD_BITS'((k < 15) ? $urandom_range(0, 4095) : $urandom_range(300, 3800));
                k = $urandom_range(0, 99);
                r = (COORD_BITS-1)'((k < 8) ? 0 : (k < 18) ? $urandom_range(0, 2047)
                                                            : $urandom_range(1, 250));
                k = $urandom_range(0, 99);
                len = (k < 25) ? 1 : (k < 90) ? $urandom_range(2, 10) : $urandom_range(11, 30);
            end
            for (int i = 0; i < len; i++) begin
                k = $urandom_range(0, 99);
                span = int'(r) * 4 + 20;
                if (span > 4095) span = 4095;
                if (mode < 12) begin
                    // alternate sides above the palm, d = 2.5r
                    side = (i % 2) ? 2 * int'(r) : -2 * int'(r);
                    px = clamp_coord(int'(cx) + side);
                    py = clamp_coord(int'(cy) - (3 * int'(r)) / 2);
                end else if (mode < 30 && i > 0) begin
                    // gapless frame: every step stays under the gap limit
                    step = int'(gap_cfg) / 2;
                    px = clamp_coord(int'(px) + int'($urandom_range(0, 2 * step)) - step);
                    py = clamp_coord(int'(py) + int'($urandom_range(0, 2 * step)) - step);
                end else if (k < 65 || (mode < 30)) begin
                    px = clamp_coord(int'(cx) + int'($urandom_range(0, 2 * span)) - span);
                    py = clamp_coord(int'(cy) + int'($urandom_range(0, 2 * span)) - span);
                end else if (k < 80) begin
                    px = clamp_coord(int'(px) + int'($urandom_range(0, 60)) - 30);
                    py = clamp_coord(int'(py) + int'($urandom_range(0, 60)) - 30);
                end else begin
                    px = COORD_BITS'($urandom_range(0, 4095));
                    py = COORD_BITS'($urandom_range(0, 4095));
                end
                // move the palm mid-frame now and then
                if ($urandom_range(0, 99) < 5) begin
                    cx = COORD_BITS'($urandom_range(0, 4095));
                    cy = COORD_BITS'($urandom_range(0, 4095));
                    r = (COORD_BITS-1)'($urandom_range(0, 400));
                end
                p = pt(int'(px), int'(py), int'(cx), int'(cy), int'(r), i == len - 1);
                send_point(p);
                sent++;
            end
        end
    endtask

    task automatic test_directed_shapes();
        // single point right on the inner ring edge
        send_point(pt(1000, 800, 1000, 1000, 100, 1'b1));
        // gapless frame, first point right on the outer ring edge
        send_point(pt(1000, 620, 1000, 1000, 100, 1'b0));
        send_point(pt(1005, 620, 1000, 1000, 100, 1'b0));
        send_point(pt(1010, 620, 1000, 1000, 100, 1'b1));
        // gap candidates judged by the next point's palm; third one sits on the y limit
        send_point(pt(1000, 800, 0, 0, 0, 1'b0));
        send_point(pt(1300, 1000, 1000, 1000, 100, 1'b0));
        send_point(pt(700, 1100, 1000, 1000, 100, 1'b0));
        send_point(pt(1000, 1500, 1000, 1000, 100, 1'b1));
        // field extremes
        send_point(pt(0, 0, 4095, 4095, 2047, 1'b0));
        send_point(pt(4095, 4095, 0, 0, 2047, 1'b1));
        send_point(pt(0, 0, 0, 0, 0, 1'b1));
        send_point(pt(4095, 4095, 4095, 4095, 2047, 1'b1));
        // one row below the palm edge
        send_point(pt(1300, 1101, 1000, 1000, 100, 1'b1));
        // eight qualifying gap candidates: total saturates, cap applies
        for (int i = 0; i < 9; i++)
            send_point(pt((i % 2) ? 1200 : 800, 1000, 1000, 1000, 100, i == 8));
        settle();
    endtask

    task automatic test_register_extremes();
        apply_setting(0, 7);
        run_random_frames(100);
        apply_setting(255, 1);
        run_random_frames(90);
        apply_setting(18, 0);
        run_random_frames(70);
        apply_setting(10, 3);
        run_random_frames(100);
        apply_setting(40, 7);
        run_random_frames(100);
    endtask

    task automatic test_steady_stream();
        apply_setting(25, 6);
        no_idle = 1'b1;
        run_random_frames(80);
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hull_point_t p;
        apply_setting(18, 7);
        hold_cycles = HOLD_OFF;
        // short frames so frame-end requests pile up behind the stalled output
        for (int i = 0; i < 70; i++) begin
            p = pt($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 2047), 1'($urandom_range(0, 1)));
            if (i == 69) p.last_point = 1'b1;
            send_point(p);
        end
        settle();
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left, g;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                stall_left = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                g = pick_idle();
                m_ready <= (g == 0);
                if (g > 0) stall_left = g - 1;
            end
        end
    end

    always @(posedge aclk) begin
        frame_count_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
                $error("unexpected result: tip_count %0d raw_count %0d",
                       m_tip_count, m_raw_count);
                fail_count++;
            end else begin
                want = expected_counts.pop_front();
                if (m_tip_count !== want.tip_count) begin
                    $error("tip_count: expected %0d, got %0d", want.tip_count, m_tip_count);
                    fail_count++;
                end
                if (m_raw_count !== want.raw_count) begin
                    $error("raw_count: expected %0d, got %0d", want.raw_count, m_raw_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL fingertip_counter");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_shapes();
        test_register_extremes();
        test_steady_stream();
        test_output_backpressure();
        settle();
        if (expected_counts.size() != 0) begin
            $error("%0d frame counts never arrived", expected_counts.size());
            fail_count++;
        end
        $display("Sent %0d hull points in %0d frames, checked %0d counts", points_sent,
                 frames_sent, results_seen);
        $display("Ran %0d register settings with random stalls and one long output hold-off",
                 settings_used + 1);
        if (fail_count == 0) begin
            $display("PASS fingertip_counter");
        end else begin
            $display("FAIL fingertip_counter");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fc_pkg.sv
rtl/core/fc_config.sv
rtl/core/fc_geometry.sv
rtl/core/fc_qualify.sv
rtl/core/fc_tally.sv
rtl/core/fc_smooth.sv
rtl/core/fingertip_counter.sv
tb/testbench.sv
